// ----- hw/rtl/palette_lookup_pixel_upscaler_top_macros.svh -----
// Assertion macros for the upscaler top RTL.
`ifndef PALETTE_LOOKUP_PIXEL_UPSCALER_TOP_MACROS_SVH
`define PALETTE_LOOKUP_PIXEL_UPSCALER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PLU_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("upscaler assertion failed");
`define PLU_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("upscaler assertion failed");
`else
`define PLU_ASSERT_IMP(name, ante, cons)
`define PLU_ASSERT_NXT(name, ante, cons)
`endif
`endif

// ----- hw/rtl/plu_pkg.sv -----
// Constants and codes of the palette lookup pixel upscaler.
`default_nettype none

package plu_pkg;

	localparam int unsigned PAL_ENTRIES = 256;
	localparam int unsigned PAL_AW      = 8;
	localparam int unsigned PAL_W       = 12;
	localparam int unsigned CHAN_W      = 8;
	localparam int unsigned ADDR_W      = 24;
	localparam int unsigned COLOR_W     = 16;
	localparam int unsigned IN_DATA_W   = 40;
	localparam int unsigned OUT_DATA_W  = 40;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 11;
	localparam int unsigned SCALE_W     = 2;

	localparam logic [3:0] ALPHA_OPAQUE = 4'hF;

	localparam logic OP_PALETTE = 1'b0;
	localparam logic OP_PIXEL   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

	localparam int unsigned WIDTH_RESET  = 320;
	localparam int unsigned HEIGHT_RESET = 200;

	typedef logic [PAL_W-1:0] pal_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/palette_lookup_pixel_upscaler_top.sv -----
// Palette lookup and nearest-neighbor upscaler to ABGR4444 (alpha in the top bits) with framebuffer addresses.
//
// Channel   Dir  Data                                                    Side
// s_axis    in   tdata: slot, red, green, blue, pixel_value; tuser: op    stream
// m_axis    out  tdata: dest_address, out_color; tlast: pixel end; tuser: frame end  stream
// cfg       in   cfg_we, cfg_index, cfg_data                              write only
//
// A pixel word makes scale*scale output words (1, 4 or 9), one per cycle from the copy
// generator while the output is not stalled. The first copy passes the palette read and
// s1 registers, the copy generator and the output register. The palette is a 256-entry
// RAM with a registered read; it has no reset and an entry never written reads as garbage.
// Output stalls hold the generator and then the input stage.
`default_nettype none
`include "palette_lookup_pixel_upscaler_top_macros.svh"

module palette_lookup_pixel_upscaler_top #(
	parameter int unsigned MAX_WIDTH  = 1024,
	parameter int unsigned MAX_HEIGHT = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// palette_slot, red, green, blue, pixel_value
	input  wire logic [plu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// opcode
	input  wire logic                             s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// dest_address, out_color
	output logic [plu_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	output logic                                  m_axis_tlast,
	// frame_last
	output logic                                  m_axis_tuser,
	input  wire logic                             cfg_we,
	input  wire logic [plu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [plu_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned RCW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW  = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned SW  = plu_pkg::SCALE_W;
	localparam int unsigned AW  = plu_pkg::ADDR_W;
	localparam int unsigned W_RESET =
		(plu_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : plu_pkg::WIDTH_RESET;
	localparam int unsigned H_RESET =
		(plu_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : plu_pkg::HEIGHT_RESET;

	function automatic logic [31:0] clamp_dim(input logic [plu_pkg::CFG_DATA_W-1:0] v,
		input int unsigned maxv);
		logic [31:0] res;
		if (v == '0) begin
			res = 32'd1;
		end else if (32'(v) > 32'(maxv)) begin
			res = 32'(maxv);
		end else begin
			res = 32'(v);
		end
		return res;
	endfunction

	logic [SW-1:0]  scale_q;
	logic [WW-1:0]  width_q;
	logic [HW-1:0]  height_q;
	logic [CW-1:0]  col_q;
	logic [RCW-1:0] row_q;

	logic                              op;
	logic [plu_pkg::PAL_AW-1:0]        slot;
	logic [plu_pkg::CHAN_W-1:0]        red, green, blue;
	logic [plu_pkg::PAL_AW-1:0]        pixel_value;
	logic                              in_acc, pix_acc, pal_acc;
	logic [WW:0]                       col_inc;
	logic [HW:0]                       row_inc;
	logic                              row_end, frame_end;

	plu_pkg::pal_entry_t               palette_mem [plu_pkg::PAL_ENTRIES];
	plu_pkg::pal_entry_t               rdata_q;

	logic                              s1_valid_q;
	logic [CW+1:0]                     cs_s1;
	logic [RCW+1:0]                    rs_s1;
	logic [WW+1:0]                     dstw_s1;
	logic [SW-1:0]                     scale_s1;
	logic                              fend_s1;
	logic [AW-1:0]                     base;

	logic                              gen_valid_s2;
	logic [AW-1:0]                     row_addr_s2;
	plu_pkg::pal_entry_t               color_s2;
	logic [WW+1:0]                     dstw_s2;
	logic [SW-1:0]                     scale_s2;
	logic                              fend_s2;
	logic [SW-1:0]                     dx_s2, dy_s2;
	logic                              gen_last, out_take, gen_step, gen_done, gen_free, s1_adv;

	assign op          = s_axis_tuser;
	assign slot        = s_axis_tdata[7:0];
	assign red         = s_axis_tdata[15:8];
	assign green       = s_axis_tdata[23:16];
	assign blue        = s_axis_tdata[31:24];
	assign pixel_value = s_axis_tdata[39:32];

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign pix_acc = in_acc && (op == plu_pkg::OP_PIXEL);
	assign pal_acc = in_acc && (op == plu_pkg::OP_PALETTE);

	assign col_inc   = (WW+1)'(col_q) + (WW+1)'(1);
	assign row_inc   = (HW+1)'(row_q) + (HW+1)'(1);
	assign row_end   = col_inc >= (WW+1)'(width_q);
	assign frame_end = row_end && (row_inc >= (HW+1)'(height_q));

	assign out_take = !m_axis_tvalid || m_axis_tready;
	assign gen_last = (dx_s2 == scale_s2 - SW'(1)) && (dy_s2 == scale_s2 - SW'(1));
	assign gen_step = gen_valid_s2 && out_take;
	assign gen_done = gen_step && gen_last;
	assign gen_free = !gen_valid_s2 || gen_done;
	assign s1_adv   = s1_valid_q && gen_free;
	assign s_axis_tready = !s1_valid_q || gen_free;

	assign base = AW'(rs_s1) * AW'(dstw_s1) + AW'(cs_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= SW'(1);
			width_q  <= WW'(W_RESET);
			height_q <= HW'(H_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				plu_pkg::CFG_SCALE: begin
					scale_q <= (cfg_data[SW-1:0] == '0) ? SW'(1) : cfg_data[SW-1:0];
				end
				plu_pkg::CFG_WIDTH: begin
					width_q <= WW'(clamp_dim(cfg_data, MAX_WIDTH));
				end
				plu_pkg::CFG_HEIGHT: begin
					height_q <= HW'(clamp_dim(cfg_data, MAX_HEIGHT));
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + RCW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pal_acc) begin
			palette_mem[slot] <= {blue[7:4], green[7:4], red[7:4]};
		end
		if (pix_acc) begin
			rdata_q <= palette_mem[pixel_value];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= pix_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			cs_s1    <= (CW+2)'(col_q) * (CW+2)'(scale_q);
			rs_s1    <= (RCW+2)'(row_q) * (RCW+2)'(scale_q);
			dstw_s1  <= (WW+2)'(width_q) * (WW+2)'(scale_q);
			scale_s1 <= scale_q;
			fend_s1  <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_valid_s2 <= 1'b0;
			dx_s2        <= '0;
			dy_s2        <= '0;
		end else if (s1_adv) begin
			gen_valid_s2 <= 1'b1;
			dx_s2        <= '0;
			dy_s2        <= '0;
		end else if (gen_done) begin
			gen_valid_s2 <= 1'b0;
		end else if (gen_step) begin
			if (dx_s2 == scale_s2 - SW'(1)) begin
				dx_s2 <= '0;
				dy_s2 <= dy_s2 + SW'(1);
			end else begin
				dx_s2 <= dx_s2 + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			row_addr_s2 <= base;
			color_s2    <= rdata_q;
			dstw_s2     <= dstw_s1;
			scale_s2    <= scale_s1;
			fend_s2     <= fend_s1;
		end else if (gen_step && (dx_s2 == scale_s2 - SW'(1))) begin
			row_addr_s2 <= row_addr_s2 + AW'(dstw_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (gen_step) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_step) begin
			m_axis_tdata <= {plu_pkg::ALPHA_OPAQUE, color_s2, row_addr_s2 + AW'(dx_s2)};
			m_axis_tlast <= gen_last;
			m_axis_tuser <= gen_last && fend_s2;
		end
	end

	`PLU_ASSERT_IMP(a_copy_in_range, gen_valid_s2,
		(dx_s2 < scale_s2) && (dy_s2 < scale_s2))
	`PLU_ASSERT_IMP(a_frame_end_on_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
	`PLU_ASSERT_IMP(a_ready_low_only_when_busy, !s_axis_tready, s1_valid_q && gen_valid_s2)
	`PLU_ASSERT_NXT(a_s1_held_while_busy, s1_valid_q && !gen_free, s1_valid_q)

endmodule

`default_nettype wire

// ----- dv/palette_lookup_pixel_upscaler_checker.sv -----
// Checker that predicts the upscaler's output words and compares them as they leave.
`default_nettype none

module palette_lookup_pixel_upscaler_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	input  wire logic                             s_axis_tready,
	// palette_slot, red, green, blue, pixel_value
	input  wire logic [plu_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// opcode
	input  wire logic                             s_axis_tuser,
	input  wire logic                             m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// dest_address, out_color
	input  wire logic [plu_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  wire logic                             m_axis_tlast,
	// frame_last
	input  wire logic                             m_axis_tuser,
	input  wire logic                             cfg_we,
	input  wire logic [plu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [plu_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                    pending,
	output int                                    failures
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_DIM = 1024;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [plu_pkg::ADDR_W-1:0]  addr;
		logic [plu_pkg::COLOR_W-1:0] color;
		logic                        run_last;
		logic                        frame_last;
	} copy_t;

	copy_t                expected_copies[$];
	plu_pkg::pal_entry_t  palette[plu_pkg::PAL_ENTRIES];
	int unsigned          column;
	int unsigned          row;
	logic [plu_pkg::SCALE_W-1:0]    scale;
	logic [plu_pkg::CFG_DATA_W-1:0] width;
	logic [plu_pkg::CFG_DATA_W-1:0] height;
	int                   fail_total = 0;

	function automatic int unsigned clamp_dim(input logic [plu_pkg::CFG_DATA_W-1:0] v);
		if (v == 0)
			return 32'd1;
		if (32'(v) > MAX_DIM)
			return MAX_DIM;
		return 32'(v);
	endfunction

	task automatic predict_copies(input logic [plu_pkg::PAL_AW-1:0] index);
		int unsigned s;
		int unsigned w;
		int unsigned h;
		int unsigned line_len;
		int unsigned addr;
		logic row_end;
		logic frame_end;
		copy_t c;
		s = (scale == 0) ? 32'd1 : 32'(scale);
		w = clamp_dim(width);
		h = clamp_dim(height);
		line_len = w * s;
		row_end = (column + 1) >= w;
		frame_end = row_end && ((row + 1) >= h);
		for (int unsigned dy = 0; dy < s; dy++) begin
			for (int unsigned dx = 0; dx < s; dx++) begin
				addr = (row * s + dy) * line_len + column * s + dx;
				c.addr = addr[plu_pkg::ADDR_W-1:0];
				c.color = {plu_pkg::ALPHA_OPAQUE, palette[index]};
				c.run_last = (dy == s - 1) && (dx == s - 1);
				c.frame_last = c.run_last && frame_end;
				expected_copies.push_back(c);
			end
		end
		if (row_end) begin
			column = 0;
			row = frame_end ? 0 : row + 1;
		end else begin
			column = column + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		copy_t got;
		copy_t want;
		if (!arst_n) begin
			expected_copies.delete();
			column = 0;
			row = 0;
			scale = 2'd1;
			width = 11'(plu_pkg::WIDTH_RESET);
			height = 11'(plu_pkg::HEIGHT_RESET);
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					plu_pkg::CFG_SCALE: scale = cfg_data[plu_pkg::SCALE_W-1:0];
					plu_pkg::CFG_WIDTH: width = cfg_data;
					plu_pkg::CFG_HEIGHT: height = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.addr = m_axis_tdata[plu_pkg::ADDR_W-1:0];
				got.color = m_axis_tdata[plu_pkg::ADDR_W +: plu_pkg::COLOR_W];
				got.run_last = m_axis_tlast;
				got.frame_last = m_axis_tuser;
				if (expected_copies.size() == 0) begin
					fail_total++;
					if (fail_total <= REPORT_LIMIT)
						$display("unexpected word: address %0h color %0h last %0b frame %0b",
							got.addr, got.color, got.run_last, got.frame_last);
				end else begin
					want = expected_copies.pop_front();
					if (got.addr !== want.addr || got.color !== want.color ||
							got.run_last !== want.run_last ||
							got.frame_last !== want.frame_last) begin
						fail_total++;
						if (fail_total <= REPORT_LIMIT)
							$display("word mismatch: expected address %0h color %0h last %0b frame %0b,",
								want.addr, want.color, want.run_last, want.frame_last,
								" got address %0h color %0h last %0b frame %0b",
								got.addr, got.color, got.run_last, got.frame_last);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == plu_pkg::OP_PALETTE)
					palette[s_axis_tdata[7:0]] = {s_axis_tdata[31:28], s_axis_tdata[23:20],
						s_axis_tdata[15:12]};
				else
					predict_copies(s_axis_tdata[39:32]);
			end
			pending <= expected_copies.size();
		end
		failures <= fail_total;
	end

endmodule

`default_nettype wire

// ----- dv/tb_palette_lookup_pixel_upscaler_top.sv -----
// Testbench top that drives palette and pixel words and settings into the upscaler.
`default_nettype none

module tb_palette_lookup_pixel_upscaler_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASES = 8;
	localparam int WORDS_PER_PHASE = 32;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [plu_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
	logic                             s_axis_tuser = 1'b0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [plu_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
	logic                             m_axis_tlast;
	logic                             m_axis_tuser;
	logic                             cfg_we = 1'b0;
	logic [plu_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
	logic [plu_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
	int                               pending;
	int                               failures;
	int                               cycles = 0;
	int                               hold_requests = 0;
	int                               burst_left = 0;
	bit                               slot_loaded[plu_pkg::PAL_ENTRIES];
	logic [plu_pkg::PAL_AW-1:0]       loaded_slots[$];

	always #5 clk = ~clk;

	palette_lookup_pixel_upscaler_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	palette_lookup_pixel_upscaler_checker upscale_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pending       (pending),
		.failures      (failures)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic send_word(input logic op, input logic [7:0] slot, input logic [7:0] red,
			input logic [7:0] green, input logic [7:0] blue, input logic [7:0] index);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {index, blue, green, red, slot};
		do @(posedge clk); while (!s_axis_tready);
		if (op == plu_pkg::OP_PALETTE && !slot_loaded[slot]) begin
			slot_loaded[slot] = 1'b1;
			loaded_slots.push_back(slot);
		end
	endtask

	function automatic logic [7:0] loaded_slot();
		return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
	endfunction

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [1:0] scale, input logic [10:0] width,
			input logic [10:0] height);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= plu_pkg::CFG_SCALE;
		cfg_data <= 11'(scale);
		@(posedge clk);
		cfg_index <= plu_pkg::CFG_WIDTH;
		cfg_data <= width;
		@(posedge clk);
		cfg_index <= plu_pkg::CFG_HEIGHT;
		cfg_data <= height;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [10:0] pick_dim();
		case ($urandom_range(0, 5))
			0: return 11'd1;
			1: return 11'd1024;
			2: return 11'($urandom_range(1, 1024));
			default: return 11'($urandom_range(1, 6));
		endcase
	endfunction

	initial begin : sink
		int served;
		int mode;
		int seg_len;
		served = 0;
		wait (arst_n);
		forever begin
			if (hold_requests > served) begin
				served++;
				repeat (HOLD_CYCLES) begin
					@(posedge clk);
					m_axis_tready <= 1'b0;
				end
			end else begin
				mode = $urandom_range(0, 3);
				seg_len = $urandom_range(4, 40);
				repeat (seg_len) begin
					@(posedge clk);
					case (mode)
						0: m_axis_tready <= 1'b1;
						1: m_axis_tready <= 1'($urandom_range(0, 1));
						2: m_axis_tready <= ($urandom_range(0, 4) != 0);
						default: m_axis_tready <= ($urandom_range(0, 4) == 0);
					endcase
				end
			end
		end
	end

	initial begin : stimulus
		logic [1:0] scale;
		logic [10:0] width;
		logic [10:0] height;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, extreme field values, and a read right after a write.
		send_word(plu_pkg::OP_PALETTE, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF);
		send_word(plu_pkg::OP_PALETTE, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00);
		send_word(plu_pkg::OP_PALETTE, 8'h5A, 8'h0F, 8'hF0, 8'h3C, 8'h5A);
		send_word(plu_pkg::OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
		send_word(plu_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
		send_word(plu_pkg::OP_PALETTE, 8'hA5, 8'hC3, 8'h96, 8'h69, 8'h00);
		send_word(plu_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA5);
		send_word(plu_pkg::OP_PALETTE, 8'h00, 8'h12, 8'h34, 8'h56, 8'h00);
		send_word(plu_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_word(plu_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A);

		// The column count is now past a one-pixel width.
		configure(2'd3, 11'd1, 11'd1);
		send_word(plu_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_word(plu_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
		send_word(plu_pkg::OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A);

		configure(2'd2, 11'd3, 11'd2);
		repeat (7) send_word(plu_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), loaded_slot());

		configure(2'd3, 11'd1024, 11'd1024);
		repeat (3) send_word(plu_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), loaded_slot());

		configure(2'd1, 11'd1024, 11'd1);
		repeat (2) send_word(plu_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), loaded_slot());

		for (int phase = 0; phase < PHASES; phase++) begin
			scale = 2'($urandom_range(1, 3));
			width = pick_dim();
			height = pick_dim();
			configure(scale, width, height);
			if (phase == 1 || phase == 5)
				hold_requests <= hold_requests + 1;
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				if ($urandom_range(0, 4) == 0)
					send_word(plu_pkg::OP_PALETTE, 8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom), 8'($urandom));
				else
					send_word(plu_pkg::OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom), loaded_slot());
			end
		end

		wait_idle();
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
